### sv/svx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stack machine execute unit.
package svx_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] CALL_STEP = 32'd4;

  typedef enum logic [5:0] {
    OP_NOP, OP_PUSH_ZERO, OP_PUSH_BASE, OP_PUSH_ACC, OP_DUP, OP_LOAD, OP_STORE,
    OP_FETCH, OP_POP_BASE, OP_POP_ACC, OP_CALL, OP_RET, OP_MOVE, OP_EXC,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NOT, OP_AND, OP_OR,
    OP_JMP, OP_JZ, OP_JNZ, OP_JGT, OP_JGE, OP_JLT, OP_JLE,
    OP_PRINT_CHAR, OP_PRINT_INT, OP_READ_CHAR, OP_READ_INT
  } op_e;

  typedef enum logic [1:0] {
    REG_BASE, REG_SP, REG_PC, REG_ACC
  } reg_e;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_DIV_ZERO, ERR_RANGE
  } err_e;

endpackage

### sv/svx_if.sv
`timescale 1ns / 1ps
// Handshake channels for instruction words and result words.
interface svx_in_if;
  logic              valid;
  logic              ready;
  logic [5:0]        op;
  logic signed [31:0] operand;
  logic [1:0]        src_reg;
  logic [1:0]        dst_reg;
  logic signed [31:0] read_value;
  modport source (output valid, op, operand, src_reg, dst_reg, read_value, input ready);
  modport sink   (input valid, op, operand, src_reg, dst_reg, read_value, output ready);
endinterface

interface svx_out_if;
  logic              valid;
  logic              ready;
  logic [31:0]       next_pc;
  logic              print_valid;
  logic              print_kind;
  logic signed [31:0] print_value;
  logic [1:0]        error;
  modport source (output valid, next_pc, print_valid, print_kind, print_value, error,
                  input ready);
  modport sink   (input valid, next_pc, print_valid, print_kind, print_value, error,
                  output ready);
endinterface

### sv/svx_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module svx_div import svx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic [WORD_W-1:0] quotient_o,
  output logic [WORD_W-1:0] remainder_o,
  output logic              done_o
);
  localparam int unsigned CW = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [WORD_W:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[WORD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WORD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo_q <= {quo_q[WORD_W-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;
endmodule

### sv/stack_vm_execute_unit.sv
`timescale 1ns / 1ps
// Stack machine execute unit: word stack memory, pointers, pc and accumulator.
// Sequence: an accepted word passes S_DEC and S_FIN; one stack read adds S_RDA, binary
// ops add S_RDA and S_RDB, and div and mod also wait in S_DIV on the 32-step divider.
// Throughput: one word at a time; the next word is taken once the last one has retired.
// Reset: sp, base, pc, accumulator and output valid clear at once; a clearing pass then
// zeroes every stack memory entry, and no word is accepted until that pass ends.
module stack_vm_execute_unit import svx_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svx_in_if.sink      in_i,
  svx_out_if.source   out_o
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [WORD_W:0] DEPTH_W = (WORD_W+1)'(STACK_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_RDA, S_RDB, S_DIV, S_FIN
  } state_e;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] mem_rd_q, mem_wd;
  logic [AW-1:0]     mem_ra, mem_wa;
  logic              mem_we;

  state_e state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [5:0]        op_q, op_d;
  logic [WORD_W-1:0] opd_q, opd_d, rv_q, rv_d;
  logic [1:0]        src_q, src_d, dst_q, dst_d;
  logic [WORD_W-1:0] sp_q, sp_d, bp_q, bp_d, pc_q, pc_d, acc_q, acc_d;
  logic [WORD_W-1:0] a_q, a_d, b_q, b_d;
  err_e              err_q, err_d;
  logic              pv_q, pv_d, pk_q, pk_d;
  logic [WORD_W-1:0] pval_q, pval_d;
  logic              ov_q, ov_d;
  logic [WORD_W-1:0] o_pc_q, o_pc_d, o_pval_q, o_pval_d;
  logic              o_pv_q, o_pv_d, o_pk_q, o_pk_d;
  err_e              o_err_q, o_err_d;

  op_e               opc;
  logic [WORD_W-1:0] sp_m1, sp_m2, loc_addr, ld_addr, src_val, v, bin_r, mul_r;
  logic              push_ok, pop1_ok, pop2_ok, loc_ok, ld_ok, take, vz, vn;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_q, div_r, mag_a, mag_b;

  assign opc      = op_e'(op_q);
  assign sp_m1    = sp_q - WORD_W'(1);
  assign sp_m2    = sp_q - WORD_W'(2);
  assign loc_addr = bp_q + opd_q;
  assign ld_addr  = (opc == OP_LOAD) ? loc_addr : opd_q;
  assign push_ok  = {1'b0, sp_q} < DEPTH_W;
  assign pop1_ok  = (sp_q >= WORD_W'(1)) && ({1'b0, sp_q} <= DEPTH_W);
  assign pop2_ok  = (sp_q >= WORD_W'(2)) && ({1'b0, sp_q} <= DEPTH_W);
  assign loc_ok   = {1'b0, loc_addr} < DEPTH_W;
  assign ld_ok    = {1'b0, ld_addr} < DEPTH_W;

  assign v     = mem_rd_q;
  assign vz    = (v == '0);
  assign vn    = v[WORD_W-1];
  assign mul_r = a_q * v;
  assign mag_a = a_q[WORD_W-1] ? (WORD_W'(0) - a_q) : a_q;
  assign mag_b = v[WORD_W-1] ? (WORD_W'(0) - v) : v;

  always_comb begin
    case (reg_e'(src_q))
      REG_BASE: src_val = bp_q;
      REG_SP:   src_val = sp_q;
      REG_PC:   src_val = pc_q;
      REG_ACC:  src_val = acc_q;
      default:  src_val = acc_q;
    endcase
  end

  always_comb begin
    case (opc)
      OP_JZ:   take = vz;
      OP_JNZ:  take = !vz;
      OP_JGT:  take = !vz && !vn;
      OP_JGE:  take = !vn;
      OP_JLT:  take = vn;
      OP_JLE:  take = vz || vn;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    case (opc)
      OP_ADD:  bin_r = a_q + v;
      OP_SUB:  bin_r = a_q - v;
      OP_MUL:  bin_r = mul_r;
      OP_AND:  bin_r = a_q & v;
      OP_OR:   bin_r = a_q | v;
      default: bin_r = a_q | v;
    endcase
  end

  svx_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .quotient_o  (div_q),
    .remainder_o (div_r),
    .done_o      (div_done)
  );

  always_comb begin
    state_d = state_q;  clr_d = clr_q;
    op_d = op_q;  opd_d = opd_q;  rv_d = rv_q;  src_d = src_q;  dst_d = dst_q;
    sp_d = sp_q;  bp_d = bp_q;  pc_d = pc_q;  acc_d = acc_q;
    a_d = a_q;  b_d = b_q;
    err_d = err_q;  pv_d = pv_q;  pk_d = pk_q;  pval_d = pval_q;
    ov_d = ov_q;  o_pc_d = o_pc_q;  o_pv_d = o_pv_q;  o_pk_d = o_pk_q;
    o_pval_d = o_pval_q;  o_err_d = o_err_q;
    mem_we = 1'b0;  mem_wa = sp_q[AW-1:0];  mem_wd = '0;
    mem_ra = sp_m1[AW-1:0];
    div_start = 1'b0;
    in_i.ready = 1'b0;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d = in_i.op;  opd_d = in_i.operand;  rv_d = in_i.read_value;
          src_d = in_i.src_reg;  dst_d = in_i.dst_reg;
          err_d = ERR_NONE;  pv_d = 1'b0;  pk_d = 1'b0;  pval_d = '0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        case (opc)
          OP_PUSH_ZERO, OP_PUSH_BASE, OP_PUSH_ACC, OP_READ_INT, OP_CALL: begin
            if (!push_ok) err_d = ERR_RANGE;
            else begin
              mem_we = 1'b1;
              case (opc)
                OP_PUSH_ZERO: mem_wd = '0;
                OP_PUSH_BASE: mem_wd = bp_q;
                OP_PUSH_ACC:  mem_wd = acc_q;
                OP_CALL:      mem_wd = pc_q + CALL_STEP;
                default:      mem_wd = rv_q;
              endcase
              sp_d = sp_q + WORD_W'(1);
              if (opc == OP_CALL) pc_d = opd_q;
            end
          end
          OP_DUP: begin
            if (!(pop1_ok && push_ok)) err_d = ERR_RANGE;
            else state_d = S_RDA;
          end
          OP_LOAD, OP_FETCH: begin
            if (!(push_ok && ld_ok)) err_d = ERR_RANGE;
            else begin
              mem_ra  = ld_addr[AW-1:0];
              state_d = S_RDA;
            end
          end
          OP_STORE: begin
            if (!(pop1_ok && loc_ok)) err_d = ERR_RANGE;
            else state_d = S_RDA;
          end
          OP_POP_BASE, OP_POP_ACC, OP_RET, OP_PRINT_CHAR, OP_PRINT_INT, OP_NOT,
          OP_JZ, OP_JNZ, OP_JGT, OP_JGE, OP_JLT, OP_JLE: begin
            if (!pop1_ok) err_d = ERR_RANGE;
            else state_d = S_RDA;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: begin
            if (!pop2_ok) err_d = ERR_RANGE;
            else state_d = S_RDA;
          end
          OP_MOVE: begin
            case (reg_e'(dst_q))
              REG_BASE: bp_d  = src_val;
              REG_SP:   sp_d  = src_val;
              REG_PC:   pc_d  = src_val;
              REG_ACC:  acc_d = src_val;
              default:  acc_d = src_val;
            endcase
          end
          OP_JMP: pc_d = opd_q;
          default: ;
        endcase
      end
      S_RDA: begin
        a_d = v;
        state_d = S_FIN;
        case (opc)
          OP_DUP, OP_LOAD, OP_FETCH: begin
            mem_we = 1'b1;  mem_wd = v;
            sp_d = sp_q + WORD_W'(1);
          end
          OP_STORE: begin
            mem_we = 1'b1;  mem_wa = loc_addr[AW-1:0];  mem_wd = v;
            sp_d = sp_m1;
          end
          OP_POP_BASE: begin bp_d = v;  sp_d = sp_m1; end
          OP_POP_ACC:  begin acc_d = v; sp_d = sp_m1; end
          OP_RET:      begin pc_d = v;  sp_d = sp_m1; end
          OP_PRINT_CHAR, OP_PRINT_INT: begin
            pv_d = 1'b1;  pk_d = (opc == OP_PRINT_INT);  pval_d = v;
            sp_d = sp_m1;
          end
          OP_NOT: begin
            mem_we = 1'b1;  mem_wa = sp_m1[AW-1:0];  mem_wd = ~v;
          end
          OP_JZ, OP_JNZ, OP_JGT, OP_JGE, OP_JLT, OP_JLE: begin
            sp_d = sp_m1;
            if (take) pc_d = opd_q;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: begin
            mem_ra  = sp_m2[AW-1:0];
            state_d = S_RDB;
          end
          default: ;
        endcase
      end
      S_RDB: begin
        b_d = v;
        state_d = S_FIN;
        if (opc == OP_DIV || opc == OP_MOD) begin
          if (vz) err_d = ERR_DIV_ZERO;
          else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          mem_we = 1'b1;  mem_wa = sp_m2[AW-1:0];  mem_wd = bin_r;
          sp_d = sp_m1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;  mem_wa = sp_m2[AW-1:0];
          if (opc == OP_DIV)
            mem_wd = (a_q[WORD_W-1] != b_q[WORD_W-1]) ? (WORD_W'(0) - div_q) : div_q;
          else
            mem_wd = a_q[WORD_W-1] ? (WORD_W'(0) - div_r) : div_r;
          sp_d = sp_m1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;  o_pc_d = pc_q;  o_pv_d = pv_q;  o_pk_d = pk_q;
          o_pval_d = pval_q;  o_err_d = err_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      sp_q    <= '0;
      bp_q    <= '0;
      pc_q    <= '0;
      acc_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      bp_q    <= bp_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  opd_q <= opd_d;  rv_q <= rv_d;  src_q <= src_d;  dst_q <= dst_d;
    a_q <= a_d;  b_q <= b_d;
    err_q <= err_d;  pv_q <= pv_d;  pk_q <= pk_d;  pval_q <= pval_d;
    o_pc_q <= o_pc_d;  o_pv_q <= o_pv_d;  o_pk_q <= o_pk_d;
    o_pval_q <= o_pval_d;  o_err_q <= o_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  assign out_o.valid       = ov_q;
  assign out_o.next_pc     = o_pc_q;
  assign out_o.print_valid = o_pv_q;
  assign out_o.print_kind  = o_pk_q;
  assign out_o.print_value = o_pval_q;
  assign out_o.error       = o_err_q;
endmodule

### test/stack_vm_execute_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stack machine execute unit against an in-bench predictor.
module stack_vm_execute_unit_test;
  import svx_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned WATCHDOG = 6000;
  localparam int unsigned LONG_HOLD = 500;

  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] operand;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [31:0] rd;
    logic        drain;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        pv;
    logic        pk;
    logic [31:0] pval;
    logic [1:0]  err;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  svx_in_if  in_if ();
  svx_out_if out_if ();

  stack_vm_execute_unit #(.STACK_DEPTH(DEPTH)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  logic [31:0] vm_mem [DEPTH];
  logic [31:0] vm_sp, vm_bp, vm_pc, vm_acc;

  instr_t   pending_words[$];
  outcome_t expected_outcomes[$];
  int unsigned failures;
  int unsigned words_sent, outcomes_seen;
  int unsigned watchdog_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic vm_can_pop(input logic [31:0] n);
    return vm_sp >= n && vm_sp <= DEPTH;
  endfunction

  function automatic logic [31:0] vm_mag(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  // Advance the predicted machine by one word and return its outcome.
  function automatic outcome_t execute_word(input instr_t w);
    outcome_t    o;
    logic [31:0] a, b, v, addr, r;
    logic [31:0] regs [4];
    logic        take;
    o = '0;
    case (op_e'(w.op))
      OP_PUSH_ZERO, OP_PUSH_BASE, OP_PUSH_ACC, OP_READ_INT: begin
        v = (w.op == OP_PUSH_ZERO) ? 32'd0 : (w.op == OP_PUSH_BASE) ? vm_bp :
            (w.op == OP_PUSH_ACC) ? vm_acc : w.rd;
        if (vm_sp >= DEPTH) o.err = ERR_RANGE;
        else begin
          vm_mem[vm_sp] = v;
          vm_sp++;
        end
      end
      OP_DUP: begin
        if (!vm_can_pop(1) || vm_sp >= DEPTH) o.err = ERR_RANGE;
        else begin
          vm_mem[vm_sp] = vm_mem[vm_sp - 1];
          vm_sp++;
        end
      end
      OP_LOAD, OP_FETCH: begin
        addr = (w.op == OP_LOAD) ? vm_bp + w.operand : w.operand;
        if (vm_sp >= DEPTH || addr >= DEPTH) o.err = ERR_RANGE;
        else begin
          vm_mem[vm_sp] = vm_mem[addr];
          vm_sp++;
        end
      end
      OP_STORE: begin
        addr = vm_bp + w.operand;
        if (!vm_can_pop(1) || addr >= DEPTH) o.err = ERR_RANGE;
        else begin
          vm_mem[addr] = vm_mem[vm_sp - 1];
          vm_sp--;
        end
      end
      OP_POP_BASE, OP_POP_ACC, OP_RET, OP_PRINT_CHAR, OP_PRINT_INT: begin
        if (!vm_can_pop(1)) o.err = ERR_RANGE;
        else begin
          v = vm_mem[vm_sp - 1];
          vm_sp--;
          case (op_e'(w.op))
            OP_POP_BASE: vm_bp = v;
            OP_POP_ACC:  vm_acc = v;
            OP_RET:      vm_pc = v;
            default: begin
              o.pv = 1'b1;
              o.pk = (w.op == OP_PRINT_INT);
              o.pval = v;
            end
          endcase
        end
      end
      OP_CALL: begin
        if (vm_sp >= DEPTH) o.err = ERR_RANGE;
        else begin
          vm_mem[vm_sp] = vm_pc + 32'd4;
          vm_sp++;
          vm_pc = w.operand;
        end
      end
      OP_MOVE: begin
        regs[REG_BASE] = vm_bp;
        regs[REG_SP] = vm_sp;
        regs[REG_PC] = vm_pc;
        regs[REG_ACC] = vm_acc;
        case (reg_e'(w.dst))
          REG_BASE: vm_bp = regs[w.src];
          REG_SP:   vm_sp = regs[w.src];
          REG_PC:   vm_pc = regs[w.src];
          default:  vm_acc = regs[w.src];
        endcase
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: begin
        if (!vm_can_pop(2)) o.err = ERR_RANGE;
        else begin
          a = vm_mem[vm_sp - 1];
          b = vm_mem[vm_sp - 2];
          if ((w.op == OP_DIV || w.op == OP_MOD) && b == 0) o.err = ERR_DIV_ZERO;
          else begin
            case (op_e'(w.op))
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV: begin
                r = vm_mag(a) / vm_mag(b);
                if (a[31] != b[31]) r = 32'd0 - r;
              end
              OP_MOD: begin
                r = vm_mag(a) % vm_mag(b);
                if (a[31]) r = 32'd0 - r;
              end
              OP_AND: r = a & b;
              default: r = a | b;
            endcase
            vm_mem[vm_sp - 2] = r;
            vm_sp--;
          end
        end
      end
      OP_NOT: begin
        if (!vm_can_pop(1)) o.err = ERR_RANGE;
        else vm_mem[vm_sp - 1] = ~vm_mem[vm_sp - 1];
      end
      OP_JMP: vm_pc = w.operand;
      OP_JZ, OP_JNZ, OP_JGT, OP_JGE, OP_JLT, OP_JLE: begin
        if (!vm_can_pop(1)) o.err = ERR_RANGE;
        else begin
          v = vm_mem[vm_sp - 1];
          vm_sp--;
          case (op_e'(w.op))
            OP_JZ:   take = (v == 0);
            OP_JNZ:  take = (v != 0);
            OP_JGT:  take = (v != 0) && !v[31];
            OP_JGE:  take = !v[31];
            OP_JLT:  take = v[31];
            default: take = (v == 0) || v[31];
          endcase
          if (take) vm_pc = w.operand;
        end
      end
      default: ;
    endcase
    o.next_pc = vm_pc;
    return o;
  endfunction

  task automatic add_word(input op_e op, input logic [31:0] operand = 0,
                          input reg_e src = REG_BASE, input reg_e dst = REG_BASE,
                          input logic [31:0] rd = 0, input logic drain = 1'b0);
    instr_t w;
    w.op = op;
    w.operand = operand;
    w.src = src;
    w.dst = dst;
    w.rd = rd;
    w.drain = drain;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4, 5: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_word();
    logic [5:0]  op;
    logic [31:0] operand;
    reg_e        dst;
    op = $urandom_range(0, 19) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 32));
    case (op_e'(op))
      OP_LOAD, OP_STORE: operand = $urandom_range(0, 3) == 0 ? $urandom
                                   : $urandom_range(0, 24) - 4;
      OP_FETCH: operand = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, DEPTH - 1);
      default: operand = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
    endcase
    dst = reg_e'($urandom_range(0, 3));
    // most stack pointer moves are steered through the dedicated sequences
    if (op == OP_MOVE && dst == REG_SP && $urandom_range(0, 3) != 0) dst = REG_ACC;
    add_word(op_e'(op), operand, reg_e'($urandom_range(0, 3)), dst, pick_value());
  endtask

  initial begin
    logic [31:0] v;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = '0;
    in_if.operand = '0;
    in_if.src_reg = '0;
    in_if.dst_reg = '0;
    in_if.read_value = '0;
    out_if.ready = 1'b0;
    foreach (vm_mem[i]) vm_mem[i] = '0;
    vm_sp = '0;
    vm_bp = '0;
    vm_pc = '0;
    vm_acc = '0;

    // empty stack faults, then full-range values, arithmetic corners and address and stack range cases
    add_word(OP_POP_ACC);
    add_word(OP_ADD);
    add_word(OP_READ_INT, 0, REG_BASE, REG_BASE, 32'hFFFF_FFFF);
    add_word(OP_READ_INT, 0, REG_BASE, REG_BASE, 32'h8000_0000);
    add_word(OP_DIV);
    add_word(OP_PUSH_ZERO);
    add_word(OP_READ_INT, 0, REG_BASE, REG_BASE, 32'h7FFF_FFFF);
    add_word(OP_MOD);
    add_word(OP_DUP);
    add_word(OP_PRINT_INT);
    add_word(OP_PRINT_CHAR);
    add_word(OP_FETCH, DEPTH - 1);
    add_word(OP_FETCH, DEPTH);
    add_word(OP_FETCH, 32'hFFFF_FFFF);
    add_word(OP_STORE, 32'hFFFF_FFFF);
    add_word(OP_CALL, 32'hFFFF_FFFC);
    add_word(OP_RET);
    add_word(OP_JMP, DEPTH);
    add_word(OP_MOVE, 0, REG_PC, REG_SP);
    add_word(OP_PUSH_ACC);
    add_word(OP_JMP, 32'hFFFF_FFFF);
    add_word(OP_MOVE, 0, REG_PC, REG_SP);
    add_word(OP_NOT);
    add_word(OP_JMP, 2);
    add_word(OP_MOVE, 0, REG_PC, REG_SP, 0, 1'b1);

    while (pending_words.size() < 1700) begin
      case ($urandom_range(0, 9))
        0: begin
          // relocate the stack pointer, run a while, then set it to a small value from 8 to 200
          case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = DEPTH - $urandom_range(0, 2);
            default: v = $urandom_range(0, 3);
          endcase
          add_word(OP_JMP, v);
          add_word(OP_MOVE, 0, REG_PC, REG_SP);
          repeat ($urandom_range(1, 6)) add_random_word();
          add_word(OP_JMP, $urandom_range(8, 200));
          add_word(OP_MOVE, 0, REG_PC, REG_SP);
        end
        1: begin
          add_word(OP_JMP, $urandom_range(0, 32));
          add_word(OP_MOVE, 0, REG_PC, REG_BASE);
        end
        2: begin
          add_word(OP_READ_INT, 0, REG_BASE, REG_BASE, pick_value());
          add_word(OP_READ_INT, 0, REG_BASE, REG_BASE, pick_value());
          add_word(op_e'($urandom_range(OP_ADD, OP_OR)));
          add_word(op_e'($urandom_range(OP_JZ, OP_PRINT_INT)), $urandom);
        end
        default: add_random_word();
      endcase
      if (pending_words.size() >= 900 && pending_words.size() < 905)
        pending_words[$].drain = 1'b1;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_words.size() == 0 && !in_if.valid && expected_outcomes.size() == 0);
    repeat (60) @(posedge clk_i);
    if (failures == 0 && expected_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // word driver
  int unsigned gap_cnt;
  logic        send_quiet;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_cnt <= 0;
      send_quiet <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      expected_outcomes.push_back(execute_word({in_if.op, in_if.operand, in_if.src_reg,
                                                in_if.dst_reg, in_if.read_value, 1'b0}));
      words_sent++;
      if (words_sent % 64 == 0) send_quiet <= ($urandom_range(0, 2) == 0);
      in_if.valid <= 1'b0;
      gap_cnt <= send_quiet ? 0 : $urandom_range(0, 18);
    end else if (!in_if.valid) begin
      if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain && expected_outcomes.size() != 0)) begin
        in_if.op <= pending_words[0].op;
        in_if.operand <= pending_words[0].operand;
        in_if.src_reg <= pending_words[0].src;
        in_if.dst_reg <= pending_words[0].dst;
        in_if.read_value <= pending_words[0].rd;
        in_if.valid <= 1'b1;
        void'(pending_words.pop_front());
      end
    end
  end

  // result monitor
  int unsigned hold_cnt;
  logic        recv_quiet;
  outcome_t    want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
      recv_quiet <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      outcomes_seen++;
      if (expected_outcomes.size() == 0) begin
        failures++;
        $display("%0t: unexpected result pc=%h err=%0d", $time, out_if.next_pc, out_if.error);
      end else begin
        want = expected_outcomes.pop_front();
        if (out_if.next_pc !== want.next_pc) begin
          failures++;
          $display("%0t: next_pc expected %h got %h", $time, want.next_pc, out_if.next_pc);
        end
        if (out_if.print_valid !== want.pv) begin
          failures++;
          $display("%0t: print_valid expected %b got %b", $time, want.pv, out_if.print_valid);
        end
        if (out_if.print_kind !== want.pk) begin
          failures++;
          $display("%0t: print_kind expected %b got %b", $time, want.pk, out_if.print_kind);
        end
        if (out_if.print_value !== want.pval) begin
          failures++;
          $display("%0t: print_value expected %h got %h", $time, want.pval,
                   out_if.print_value);
        end
        if (out_if.error !== want.err) begin
          failures++;
          $display("%0t: error expected %0d got %0d", $time, want.err, out_if.error);
        end
      end
      if (outcomes_seen % 64 == 0) recv_quiet <= ($urandom_range(0, 2) == 0);
      out_if.ready <= 1'b0;
      if (outcomes_seen == 600) hold_cnt <= LONG_HOLD;
      else hold_cnt <= recv_quiet ? 0 : $urandom_range(0, 18);
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      watchdog_cnt <= 0;
    end else if (watchdog_cnt >= WATCHDOG) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
      $display("*** FAILED ***");
      $finish;
    end else begin
      watchdog_cnt <= watchdog_cnt + 1;
    end
  end

endmodule

### files.f
sv/svx_pkg.sv
sv/svx_if.sv
sv/svx_div.sv
sv/stack_vm_execute_unit.sv
test/stack_vm_execute_unit_test.sv
